// File: sv/mdc_pkg.sv
// Shared types and constants for the metered dispense controller.
// No dependencies; every other file in this folder imports this package.
package mdc_pkg;

  localparam int VolW = 24;
  localparam int CfgW = 16;
  localparam int CntW = 16;

  localparam logic [VolW-1:0] VolMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] VppReset       = 16'd512;
  localparam logic [CfgW-1:0] StartTmoReset  = 16'd10000;
  localparam logic [CfgW-1:0] GapTmoReset    = 16'd5000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_VPP       = 2'd0,
    CFG_START_TMO = 2'd1,
    CFG_GAP_TMO   = 2'd2
  } cfg_idx_t;

  // Request kinds; code 3 carries no meaning and is ignored.
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_PULSE = 2'd1,
    REQ_TICK  = 2'd2
  } req_kind_t;

  // Reported phase codes.
  typedef enum logic [1:0] {
    FP_IDLE  = 2'd0,
    FP_AWAIT = 2'd1,
    FP_FLOW  = 2'd2,
    FP_DONE  = 2'd3
  } flow_phase_t;

  typedef enum logic [2:0] {
    EV_RELEASED      = 3'd0,
    EV_STARTED       = 3'd1,
    EV_UPDATE        = 3'd2,
    EV_EXHAUSTED     = 3'd3,
    EV_STOPPED       = 3'd4,
    EV_START_TIMEOUT = 3'd5,
    EV_REJECTED      = 3'd6
  } event_t;

  // Internal controller state, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_AWAIT = 3'b010,
    ST_FLOW  = 3'b100
  } state_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [VolW-1:0] grant_volume;
  } req_t;

  typedef struct packed {
    logic [1:0]      flow_phase;
    logic [2:0]      event_code;
    logic [VolW-1:0] used_volume;
    logic [VolW-1:0] left_volume;
    logic            valve_open;
  } rpt_t;

  typedef struct packed {
    logic [CfgW-1:0] vpp;
    logic [CfgW-1:0] start_tmo;
    logic [CfgW-1:0] gap_tmo;
  } cfg_t;

endpackage

// File: sv/mdc_core.sv
// Dispense state machine: holds the dispense state and works out one word per cycle while fire is high.
// Depends on mdc_pkg.
module mdc_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  mdc_pkg::req_t req,
  input  mdc_pkg::cfg_t cfg,
  output logic          res_valid,
  output mdc_pkg::rpt_t res
);
  import mdc_pkg::*;

  state_t          state, state_next;
  logic [CntW-1:0] pulse_total, pulse_total_next;
  logic [CntW-1:0] wait_timer, wait_timer_next;
  logic [VolW-1:0] granted, granted_next;
  logic [VolW-1:0] consumed, consumed_next;
  logic            valve, valve_next;

  logic [CntW-1:0]      cnt_inc, wt_inc, mul_cnt;
  logic [2*CfgW-1:0]    prod;
  logic [VolW-1:0]      vol_sat, bal_cons, bal_vol;
  logic [1:0]           cur_code;

  always_comb begin
    cnt_inc = (pulse_total == CntMax) ? pulse_total : pulse_total + 1'b1;
    wt_inc  = (wait_timer == CntMax) ? wait_timer : wait_timer + 1'b1;
    // A pulse counts up before the volume is taken; a stop uses the count as it is.
    mul_cnt = (req.req_type == REQ_PULSE) ? cnt_inc : pulse_total;
    prod    = mul_cnt * cfg.vpp;
    vol_sat = (prod[2*CfgW-1:VolW] != '0) ? VolMax : prod[VolW-1:0];
    bal_cons = (consumed >= granted) ? '0 : granted - consumed;
    bal_vol  = (vol_sat >= granted) ? '0 : granted - vol_sat;
    case (state)
      ST_AWAIT: cur_code = FP_AWAIT;
      ST_FLOW:  cur_code = FP_FLOW;
      default:  cur_code = FP_IDLE;
    endcase
  end

  always_comb begin
    state_next       = state;
    pulse_total_next = pulse_total;
    wait_timer_next  = wait_timer;
    granted_next     = granted;
    consumed_next    = consumed;
    valve_next       = valve;
    res_valid        = 1'b0;
    res              = '{flow_phase: cur_code, event_code: EV_REJECTED,
                         used_volume: consumed, left_volume: bal_cons, valve_open: valve};
    case (req.req_type)
      REQ_START: begin
        res_valid = 1'b1;
        if (state == ST_IDLE) begin
          granted_next     = req.grant_volume;
          consumed_next    = '0;
          pulse_total_next = '0;
          wait_timer_next  = '0;
          valve_next       = 1'b1;
          state_next       = ST_AWAIT;
          res = '{flow_phase: FP_AWAIT, event_code: EV_RELEASED, used_volume: '0,
                  left_volume: req.grant_volume, valve_open: 1'b1};
        end
      end
      REQ_PULSE: begin
        if (state == ST_AWAIT) begin
          res_valid        = 1'b1;
          pulse_total_next = {{(CntW-1){1'b0}}, 1'b1};
          wait_timer_next  = '0;
          state_next       = ST_FLOW;
          res = '{flow_phase: FP_FLOW, event_code: EV_STARTED, used_volume: consumed,
                  left_volume: bal_cons, valve_open: valve};
        end else if (state == ST_FLOW) begin
          res_valid       = 1'b1;
          wait_timer_next = '0;
          if (vol_sat >= granted) begin
            consumed_next    = granted;
            valve_next       = 1'b0;
            state_next       = ST_IDLE;
            pulse_total_next = '0;
            res = '{flow_phase: FP_DONE, event_code: EV_EXHAUSTED, used_volume: granted,
                    left_volume: '0, valve_open: 1'b0};
          end else begin
            pulse_total_next = cnt_inc;
            consumed_next    = vol_sat;
            res = '{flow_phase: FP_FLOW, event_code: EV_UPDATE, used_volume: vol_sat,
                    left_volume: granted - vol_sat, valve_open: valve};
          end
        end
      end
      REQ_TICK: begin
        if (state == ST_AWAIT || state == ST_FLOW) begin
          wait_timer_next = wt_inc;
          if (state == ST_AWAIT && wt_inc >= cfg.start_tmo) begin
            res_valid        = 1'b1;
            consumed_next    = '0;
            valve_next       = 1'b0;
            state_next       = ST_IDLE;
            pulse_total_next = '0;
            wait_timer_next  = '0;
            res = '{flow_phase: FP_DONE, event_code: EV_START_TIMEOUT, used_volume: '0,
                    left_volume: granted, valve_open: 1'b0};
          end else if (state == ST_FLOW && wt_inc >= cfg.gap_tmo) begin
            res_valid        = 1'b1;
            consumed_next    = vol_sat;
            valve_next       = 1'b0;
            state_next       = ST_IDLE;
            pulse_total_next = '0;
            wait_timer_next  = '0;
            res = '{flow_phase: FP_DONE, event_code: EV_STOPPED, used_volume: vol_sat,
                    left_volume: bal_vol, valve_open: 1'b0};
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pulse_total <= '0;
      wait_timer  <= '0;
      granted     <= '0;
      consumed    <= '0;
      valve       <= 1'b0;
    end else if (fire) begin
      state       <= state_next;
      pulse_total <= pulse_total_next;
      wait_timer  <= wait_timer_next;
      granted     <= granted_next;
      consumed    <= consumed_next;
      valve       <= valve_next;
    end
  end

endmodule

// File: sv/mdc_out_buf.sv
// Two-entry result buffer between the controller and the report channel.
// Depends on mdc_pkg.
module mdc_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mdc_pkg::rpt_t push_data,
  output logic          full,
  output logic          rpt_valid,
  input  logic          rpt_stall,
  output mdc_pkg::rpt_t rpt
);
  import mdc_pkg::*;

  rpt_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign rpt_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign rpt       = mem[rd_ptr];
  assign pop       = rpt_valid && !rpt_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/metered_dispense_controller.sv
// Top level of the metered dispense controller: input register, config registers,
// controller and result buffer. Depends on mdc_pkg, mdc_core and mdc_out_buf.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req (req_type, grant_volume)
//   rpt       out        rpt_valid/rpt_stall  rpt (phase, event, volumes, valve)
//   cfg       in         cfg_we               cfg_index, cfg_data
//
// A word sits in the input register while the controller works it out, and its
// report is offered once the controller takes it; one word per cycle is sustained
// unless the two-entry result buffer is full, and only then is the input stalled.
// Reset is synchronous and restores the idle state and the config defaults.
module metered_dispense_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  mdc_pkg::req_t             req,
  output logic                      rpt_valid,
  input  logic                      rpt_stall,
  output mdc_pkg::rpt_t             rpt,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [mdc_pkg::CfgW-1:0]  cfg_data
);
  import mdc_pkg::*;

  cfg_t  cfg;
  req_t  held;
  logic  held_valid;
  logic  buf_full;
  logic  fire;
  logic  res_valid;
  rpt_t  res;

  assign fire      = held_valid && !buf_full;
  assign req_stall = held_valid && buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vpp       <= VppReset;
      cfg.start_tmo <= StartTmoReset;
      cfg.gap_tmo   <= GapTmoReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VPP:       cfg.vpp       <= cfg_data;
        CFG_START_TMO: cfg.start_tmo <= cfg_data;
        CFG_GAP_TMO:   cfg.gap_tmo   <= cfg_data;
        default:       cfg           <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!req_stall) begin
      held_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      held <= req;
    end
  end

  mdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .req       (held),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  mdc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire && res_valid),
    .push_data (res),
    .full      (buf_full),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt)
  );

endmodule

// File: bench/metered_dispense_controller_tb.sv
// Self-checking bench for metered_dispense_controller: random-timed request and report
// channels, a cycle-free predictor of the dispense state, and field-by-field checking.
// Depends on mdc_pkg and the metered_dispense_controller RTL.
module metered_dispense_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdc_pkg::*;

  // Request code 3 has no meaning and must be ignored.
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int HoldCycles = 80;
  localparam int SettleCycles = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rpt_valid;
  logic rpt_stall = 1'b0;
  rpt_t rpt;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_VPP;
  logic [CfgW-1:0] cfg_data = '0;

  metered_dispense_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the dispense controller as seen one word at a time.
  // ---------------------------------------------------------------------------
  cfg_t regs;
  flow_phase_t dsp_phase;
  logic [CntW-1:0] dsp_pulses;
  logic [CntW-1:0] dsp_ticks;
  logic [VolW-1:0] dsp_granted;
  logic [VolW-1:0] dsp_consumed;
  logic dsp_valve;

  req_t words_to_send[$];
  rpt_t reports_due[$];
  int unsigned words_queued = 0;
  int unsigned mismatch_count = 0;

  logic req_calm = 1'b0;
  logic rpt_calm = 1'b0;
  logic hold_rpt_go = 1'b0;
  logic rpt_held = 1'b0;
  logic req_took = 1'b0;
  logic rpt_took = 1'b0;
  int unsigned req_gap_left = 0;
  int unsigned rpt_wait_left = 0;

  function automatic logic [VolW-1:0] metered_volume();
    logic [2*CfgW-1:0] prod;
    prod = dsp_pulses * regs.vpp;
    return (prod > VolMax) ? VolMax : prod[VolW-1:0];
  endfunction

  function automatic logic [VolW-1:0] left_after(input logic [VolW-1:0] used);
    return (used >= dsp_granted) ? '0 : dsp_granted - used;
  endfunction

  function automatic logic [VolW-1:0] rand_vol();
    return VolW'($urandom);
  endfunction

  task automatic expect_report(input flow_phase_t ph, input event_t ev,
                               input logic [VolW-1:0] used, input logic [VolW-1:0] rest);
    rpt_t r;
    r.flow_phase  = ph;
    r.event_code  = ev;
    r.used_volume = used;
    r.left_volume = rest;
    r.valve_open  = dsp_valve;
    reports_due.push_back(r);
  endtask

  task automatic end_dispense();
    dsp_valve  = 1'b0;
    dsp_phase  = FP_IDLE;
    dsp_pulses = '0;
    dsp_ticks  = '0;
  endtask

  task automatic dispense_step(input req_t w);
    logic [VolW-1:0] used;
    case (w.req_type)
      REQ_START: begin
        if (dsp_phase != FP_IDLE) begin
          expect_report(dsp_phase, EV_REJECTED, dsp_consumed, left_after(dsp_consumed));
        end else begin
          dsp_granted  = w.grant_volume;
          dsp_consumed = '0;
          dsp_pulses   = '0;
          dsp_ticks    = '0;
          dsp_valve    = 1'b1;
          dsp_phase    = FP_AWAIT;
          expect_report(FP_AWAIT, EV_RELEASED, '0, dsp_granted);
        end
      end
      REQ_PULSE: begin
        if (dsp_phase == FP_AWAIT) begin
          // The first pulse only marks the start of flow; it never exhausts the grant.
          dsp_pulses = 16'd1;
          dsp_ticks  = '0;
          dsp_phase  = FP_FLOW;
          expect_report(FP_FLOW, EV_STARTED, dsp_consumed, left_after(dsp_consumed));
        end else if (dsp_phase == FP_FLOW) begin
          if (dsp_pulses != CntMax) dsp_pulses = dsp_pulses + 16'd1;
          dsp_ticks = '0;
          used = metered_volume();
          if (used >= dsp_granted) begin
            dsp_consumed = dsp_granted;
            end_dispense();
            expect_report(FP_DONE, EV_EXHAUSTED, dsp_granted, '0);
          end else begin
            dsp_consumed = used;
            expect_report(FP_FLOW, EV_UPDATE, used, dsp_granted - used);
          end
        end
      end
      REQ_TICK: begin
        if (dsp_phase == FP_AWAIT || dsp_phase == FP_FLOW) begin
          if (dsp_ticks != CntMax) dsp_ticks = dsp_ticks + 16'd1;
          if (dsp_phase == FP_AWAIT) begin
            if (dsp_ticks >= regs.start_tmo) begin
              dsp_consumed = '0;
              end_dispense();
              expect_report(FP_DONE, EV_START_TIMEOUT, '0, dsp_granted);
            end
          end else if (dsp_ticks >= regs.gap_tmo) begin
            used = metered_volume();
            dsp_consumed = used;
            end_dispense();
            expect_report(FP_DONE, EV_STOPPED, used, left_after(used));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [VolW-1:0] got,
                                 input logic [VolW-1:0] want);
    // Keep the log short if the design goes badly wrong.
    if (mismatch_count < 100)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver and acceptance tracking.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : req_accept
    req_took <= !rst && req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) dispense_step(req);
  end

  always @(negedge clk) begin : req_driver
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_took) begin
      // A stalled word stays on the bus unchanged.
    end else if (req_gap_left != 0) begin
      req_valid <= 1'b0;
      req_gap_left <= req_gap_left - 1;
    end else if (words_to_send.size() != 0) begin
      req_valid <= 1'b1;
      req <= words_to_send.pop_front();
      req_gap_left <= req_calm ? 0 : $urandom_range(0, 9);
    end else begin
      req_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Report sink and checker.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : rpt_sink
    int unsigned wait_n;
    if (rst) begin
      rpt_stall <= 1'b0;
    end else if (rpt_held) begin
      rpt_stall <= 1'b1;
    end else if (rpt_took && !rpt_calm) begin
      wait_n = $urandom_range(0, 9);
      rpt_stall <= (wait_n != 0);
      rpt_wait_left <= (wait_n == 0) ? 0 : wait_n - 1;
    end else if (rpt_wait_left != 0) begin
      rpt_stall <= 1'b1;
      rpt_wait_left <= rpt_wait_left - 1;
    end else begin
      rpt_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : rpt_monitor
    rpt_t want;
    rpt_took <= !rst && rpt_valid && !rpt_stall;
    if (!rst && rpt_valid && !rpt_stall) begin
      if (reports_due.size() == 0) begin
        report_mismatch("report word with none outstanding, event_code",
                        VolW'(rpt.event_code), '0);
      end else begin
        want = reports_due.pop_front();
        if (rpt.flow_phase !== want.flow_phase)
          report_mismatch("flow_phase", VolW'(rpt.flow_phase), VolW'(want.flow_phase));
        if (rpt.event_code !== want.event_code)
          report_mismatch("event_code", VolW'(rpt.event_code), VolW'(want.event_code));
        if (rpt.used_volume !== want.used_volume)
          report_mismatch("used_volume", rpt.used_volume, want.used_volume);
        if (rpt.left_volume !== want.left_volume)
          report_mismatch("left_volume", rpt.left_volume, want.left_volume);
        if (rpt.valve_open !== want.valve_open)
          report_mismatch("valve_open", VolW'(rpt.valve_open), VolW'(want.valve_open));
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering words meanwhile.
  initial begin : rpt_holdoff
    forever begin
      wait (hold_rpt_go);
      @(negedge clk);
      rpt_held <= 1'b1;
      repeat (HoldCycles) @(negedge clk);
      rpt_held <= 1'b0;
      wait (!hold_rpt_go);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] kind, input logic [VolW-1:0] vol);
    req_t w;
    w.req_type = kind;
    w.grant_volume = vol;
    words_to_send.push_back(w);
    words_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VPP:       regs.vpp = val;
      CFG_START_TMO: regs.start_tmo = val;
      CFG_GAP_TMO:   regs.gap_tmo = val;
      default: begin
      end
    endcase
  endtask

  // Wait until every word is in and every report is out, then let any word
  // that causes no report clear the pipeline.
  task automatic wait_quiet();
    do @(posedge clk);
    while (words_to_send.size() != 0 || req_valid || reports_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One dispense with random content: a start, then mostly pulses with a few
  // ticks between them, ending in exhaustion, a stop or a start timeout, with
  // the odd stray word mixed in.
  task automatic queue_session();
    logic [39:0] g;
    logic [VolW-1:0] grant;
    logic [1:0] stray;
    int unsigned n;
    case ($urandom_range(0, 9))
      0: grant = '0;
      1: grant = VolMax;
      2, 3: grant = rand_vol();
      default: begin
        g = regs.vpp * $urandom_range(1, 20) + $urandom_range(0, regs.vpp);
        grant = (g > VolMax) ? VolMax : g[VolW-1:0];
      end
    endcase
    push_word(REQ_START, grant);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        push_word(REQ_TICK, rand_vol());
        if ($urandom_range(0, 7) == 0) push_word(REQ_START, rand_vol());
      end
    end else begin
      n = $urandom_range(1, 25);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) push_word(REQ_TICK, rand_vol());
        end
        push_word(REQ_PULSE, rand_vol());
        if ($urandom_range(0, 11) == 0) begin
          stray = 2'($urandom_range(0, 3));
          push_word(stray, rand_vol());
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(1, 12)) push_word(REQ_TICK, rand_vol());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned mark;
    regs.vpp       = VppReset;
    regs.start_tmo = StartTmoReset;
    regs.gap_tmo   = GapTmoReset;
    dsp_phase    = FP_IDLE;
    dsp_pulses   = '0;
    dsp_ticks    = '0;
    dsp_granted  = '0;
    dsp_consumed = '0;
    dsp_valve    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: 2.0 ml per pulse, so a 10 ml grant runs out on pulse five.
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_TICK, rand_vol());
    push_word(REQ_NONE, rand_vol());
    push_word(REQ_START, 24'h000A00);
    push_word(REQ_TICK, rand_vol());
    push_word(REQ_START, rand_vol());
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_NONE, rand_vol());
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_TICK, rand_vol());
    push_word(REQ_START, rand_vol());
    repeat (3) push_word(REQ_PULSE, rand_vol());
    wait_quiet();

    // A zero start timeout expires on the first tick; a zero grant runs out on
    // the second pulse; a one-tick gap timeout stops the flow.
    write_reg(CFG_START_TMO, '0);
    write_reg(CFG_GAP_TMO, 16'd1);
    push_word(REQ_START, VolMax);
    push_word(REQ_TICK, rand_vol());
    push_word(REQ_START, '0);
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_START, 24'h123456);
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_TICK, rand_vol());
    wait_quiet();

    // Count enough pulses that the largest volume per pulse overflows the
    // product, then raise the volume per pulse in mid-dispense so that the
    // stop report saturates and the balance floors.
    req_calm = 1'b1;
    rpt_calm = 1'b1;
    write_reg(CFG_VPP, 16'd1);
    write_reg(CFG_START_TMO, CntMax);
    write_reg(CFG_GAP_TMO, CntMax);
    push_word(REQ_START, 24'hFFFFF0);
    repeat (40) push_word(REQ_PULSE, rand_vol());
    push_word(REQ_TICK, rand_vol());
    push_word(REQ_START, rand_vol());
    repeat (220) push_word(REQ_PULSE, rand_vol());
    wait_quiet();
    write_reg(CFG_VPP, CntMax);
    write_reg(CFG_GAP_TMO, 16'd1);
    push_word(REQ_TICK, rand_vol());
    wait_quiet();

    // Hold the report side off while rejected starts pile up behind it.
    write_reg(CFG_VPP, VppReset);
    write_reg(CFG_START_TMO, 16'd4);
    write_reg(CFG_GAP_TMO, 16'd3);
    hold_rpt_go = 1'b1;
    @(posedge rpt_held);
    push_word(REQ_START, 24'h000400);
    repeat (10) push_word(REQ_START, rand_vol());
    push_word(REQ_PULSE, rand_vol());
    push_word(REQ_PULSE, rand_vol());
    @(negedge rpt_held);
    hold_rpt_go = 1'b0;
    wait_quiet();

    // Random dispenses over several register settings and idling mixes.
    for (int p = 0; p < 6; p++) begin
      req_calm = (p == 1 || p == 3);
      rpt_calm = (p == 2 || p == 3);
      case (p)
        1: begin
          write_reg(CFG_VPP, '0);
          write_reg(CFG_START_TMO, CfgW'($urandom_range(1, 8)));
          write_reg(CFG_GAP_TMO, CfgW'($urandom_range(1, 8)));
        end
        2: begin
          write_reg(CFG_VPP, CntMax);
          write_reg(CFG_START_TMO, 16'd1);
          write_reg(CFG_GAP_TMO, 16'd1);
        end
        3: begin
          write_reg(CFG_VPP, CfgW'($urandom_range(1, 2048)));
          write_reg(CFG_START_TMO, CfgW'($urandom_range(2, 6)));
          write_reg(CFG_GAP_TMO, CfgW'($urandom_range(2, 6)));
        end
        4: begin
          write_reg(CFG_VPP, CfgW'($urandom));
          write_reg(CFG_START_TMO, CntMax);
          write_reg(CFG_GAP_TMO, CfgW'($urandom_range(1, 10)));
        end
        default: begin
          write_reg(CFG_VPP, CfgW'($urandom));
          write_reg(CFG_START_TMO, CfgW'($urandom_range(1, 8)));
          write_reg(CFG_GAP_TMO, CfgW'($urandom_range(1, 8)));
        end
      endcase
      mark = words_queued;
      while (words_queued - mark < 32) queue_session();
      wait_quiet();
    end

    if (mismatch_count == 0 && reports_due.size() == 0) begin
      $display("metered_dispense_controller_tb: PASS");
    end else begin
      $display("metered_dispense_controller_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("metered_dispense_controller_tb: FAIL");
    $finish;
  end

endmodule
